[src/burning_ship_escape_time_macros.svh]
// assertion macros shared by the burning ship escape time block
// expects clk and rst_n in the scope where a macro is used
`ifndef BURNING_SHIP_ESCAPE_TIME_MACROS_SVH
`define BURNING_SHIP_ESCAPE_TIME_MACROS_SVH

// same-cycle implication
`define BSET_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bset assertion failed");

// next-cycle implication
`define BSET_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bset assertion failed");

`endif

[src/bset_pkg.sv]
// package for the burning ship escape time block
// types, constants and saturation helpers; no dependencies
package bset_pkg;

    localparam int MaxSize   = 1024;
    localparam int CoordW    = 10;
    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 32;
    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [CfgIndexW-1:0] RegOriginRe  = 3'd0;
    localparam logic [CfgIndexW-1:0] RegOriginIm  = 3'd1;
    localparam logic [CfgIndexW-1:0] RegPixelStep = 3'd2;
    localparam logic [CfgIndexW-1:0] RegMaxIter   = 3'd3;
    localparam logic [CfgIndexW-1:0] RegExponent  = 3'd4;

    localparam logic signed [31:0] ResetOriginRe  = -32'sd30198989;
    localparam logic signed [31:0] ResetOriginIm  = -32'sd1375732;
    localparam logic [24:0]        ResetPixelStep = 25'd2949;
    localparam logic [15:0]        ResetMaxIter   = 16'd256;
    localparam logic [2:0]         ResetExponent  = 3'd2;

    localparam logic [2:0] ExpMin = 3'd2;
    localparam logic [2:0] ExpMax = 3'd6;

    // 4.0 in q16.48
    localparam logic [64:0] EscapeLimit = 65'h4_0000_0000_0000;

    localparam logic signed [40:0] SatHigh = 41'sd2147483647;
    localparam logic signed [40:0] SatLow  = -41'sd2147483648;

    typedef struct packed {
        logic signed [31:0] origin_re;
        logic signed [31:0] origin_im;
        logic [24:0]        pixel_step;
        logic [15:0]        max_iterations;
        logic [2:0]         exponent;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] c_re;
        logic signed [31:0] c_im;
    } job_t;

    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        logic signed [31:0] r;
        if (v > SatHigh)
        begin
            r = 32'sh7fff_ffff;
        end
        else if (v < SatLow)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sabs32(input logic signed [31:0] a);
        logic signed [31:0] r;
        if (a == 32'sh8000_0000)
        begin
            r = 32'sh7fff_ffff;
        end
        else if (a < 0)
        begin
            r = -a;
        end
        else
        begin
            r = a;
        end
        return r;
    endfunction

endpackage

[src/bset_if.sv]
// channel interfaces for the burning ship escape time block
// depends on bset_pkg for field widths
interface bset_pixel_if;
    import bset_pkg::*;
    logic              valid;
    logic              ready;
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface bset_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  shade;
    logic [15:0] iteration_count;
    logic        escaped;

    modport source (output valid, output shade, output iteration_count, output escaped,
                    input ready);
    modport sink   (input valid, input shade, input iteration_count, input escaped,
                    output ready);
endinterface

interface bset_cfg_if;
    import bset_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CfgIndexW-1:0] index;
    logic [CfgDataW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/bset_front.sv]
// front end: accepts pixel words and forms the point c
// depends on bset_pkg and bset_if
module bset_front
    import bset_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    bset_pixel_if.sink  pixel,
    output logic        push_valid,
    input  logic        push_ready,
    output job_t        push_data
);

    logic              valid_reg;
    logic [34:0]       prod_x_reg;
    logic [34:0]       prod_y_reg;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic              take;

    // clamp to image size
    assign px = (pixel.pixel_x > CoordW'(MaxSize - 1)) ? CoordW'(MaxSize - 1) : pixel.pixel_x;
    assign py = (pixel.pixel_y > CoordW'(MaxSize - 1)) ? CoordW'(MaxSize - 1) : pixel.pixel_y;

    assign pixel.ready = !valid_reg || push_ready;
    assign take        = pixel.valid && pixel.ready;
    assign push_valid  = valid_reg;

    assign push_data.c_re = sat32(41'(cfg.origin_re) + 41'($signed({1'b0, prod_x_reg})));
    assign push_data.c_im = sat32(41'(cfg.origin_im) + 41'($signed({1'b0, prod_y_reg})));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pixel.ready)
        begin
            valid_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prod_x_reg <= 35'(px) * 35'(cfg.pixel_step);
            prod_y_reg <= 35'(py) * 35'(cfg.pixel_step);
        end
    end

endmodule

[src/bset_queue.sv]
// short queue of points between front end and iteration engine
// depends on bset_pkg
module bset_queue
    import bset_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    job_t                 entry_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg;
    logic [QueuePtrW-1:0] rd_ptr_reg;
    logic [QueueCntW-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != QueueCntW'(QueueDepth));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/bset_back.sv]
// iteration engine: escape test, folded power, shade divider, result register
// depends on bset_pkg, bset_if and the assertion macros header
`include "burning_ship_escape_time_macros.svh"

module bset_back
    import bset_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  job_t          pop_data,
    bset_result_if.source result
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_CMP   = 4'd2;
    localparam logic [3:0] S_MA    = 4'd3;
    localparam logic [3:0] S_MB    = 4'd4;
    localparam logic [3:0] S_MC    = 4'd5;
    localparam logic [3:0] S_ADD   = 4'd6;
    localparam logic [3:0] S_DINIT = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic               out_valid_reg, out_valid_next;

    logic signed [31:0] c_re_reg, c_re_next;
    logic signed [31:0] c_im_reg, c_im_next;
    logic signed [31:0] z_re_reg, z_re_next;
    logic signed [31:0] z_im_reg, z_im_next;
    logic signed [31:0] f_re_reg, f_re_next;
    logic signed [31:0] f_im_reg, f_im_next;
    logic signed [31:0] w_re_reg, w_re_next;
    logic signed [31:0] w_im_reg, w_im_next;
    logic signed [31:0] n_re_reg, n_re_next;
    logic signed [63:0] p0_reg, p1_reg;
    logic [15:0]        count_reg, count_next;
    logic [2:0]         k_reg, k_next;
    logic               esc_reg, esc_next;
    logic [23:0]        num_reg, num_next;
    logic [15:0]        rem_reg, rem_next;
    logic [7:0]         quo_reg, quo_next;
    logic [2:0]         bit_reg, bit_next;
    logic [7:0]         shade_reg, shade_next;
    logic [15:0]        iter_reg, iter_next;
    logic               escaped_reg, escaped_next;

    logic signed [31:0] mul_a0, mul_b0, mul_a1, mul_b1;
    logic [64:0]        mag_sum;
    logic [2:0]         power;
    logic [2:0]         mults;
    logic [2:0]         k_inc;
    logic [16:0]        count_inc;
    logic [23:0]        scaled;
    logic [16:0]        trial;
    logic               trial_ge;
    logic signed [39:0] q0, q1;

    assign power = (cfg.exponent < ExpMin) ? ExpMin :
                   (cfg.exponent > ExpMax) ? ExpMax : cfg.exponent;
    assign mults = power - 3'd1;
    assign k_inc = k_reg + 3'd1;
    assign count_inc = {1'b0, count_reg} + 17'd1;

    // floor of product / 2^24
    assign q0 = p0_reg[63:24];
    assign q1 = p1_reg[63:24];

    assign mag_sum = {1'b0, p0_reg} + {1'b0, p1_reg};
    assign scaled  = {count_reg, 8'd0} - 24'(count_reg);
    assign trial   = {rem_reg, num_reg[bit_reg]};
    assign trial_ge = (trial >= {1'b0, cfg.max_iterations});

    assign pop_ready        = (state_reg == S_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.shade           = shade_reg;
    assign result.iteration_count = iter_reg;
    assign result.escaped         = escaped_reg;

    always_comb
    begin
        case (state_reg)
            S_SQ:
            begin
                mul_a0 = z_re_reg;
                mul_b0 = z_re_reg;
                mul_a1 = z_im_reg;
                mul_b1 = z_im_reg;
            end
            S_MB:
            begin
                mul_a0 = w_re_reg;
                mul_b0 = f_im_reg;
                mul_a1 = w_im_reg;
                mul_b1 = f_re_reg;
            end
            default:
            begin
                mul_a0 = w_re_reg;
                mul_b0 = f_re_reg;
                mul_a1 = w_im_reg;
                mul_b1 = f_im_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        c_re_next      = c_re_reg;
        c_im_next      = c_im_reg;
        z_re_next      = z_re_reg;
        z_im_next      = z_im_reg;
        f_re_next      = f_re_reg;
        f_im_next      = f_im_reg;
        w_re_next      = w_re_reg;
        w_im_next      = w_im_reg;
        n_re_next      = n_re_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        esc_next       = esc_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        bit_next       = bit_reg;
        shade_next     = shade_reg;
        iter_next      = iter_reg;
        escaped_next   = escaped_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    c_re_next  = pop_data.c_re;
                    c_im_next  = pop_data.c_im;
                    z_re_next  = '0;
                    z_im_next  = '0;
                    count_next = '0;
                    esc_next   = 1'b0;
                    state_next = (cfg.max_iterations == '0) ? S_DINIT : S_SQ;
                end
            end
            S_SQ:
            begin
                f_re_next  = sabs32(z_re_reg);
                f_im_next  = sabs32(z_im_reg);
                w_re_next  = sabs32(z_re_reg);
                w_im_next  = sabs32(z_im_reg);
                k_next     = '0;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (mag_sum >= EscapeLimit)
                begin
                    esc_next   = 1'b1;
                    state_next = S_DINIT;
                end
                else
                begin
                    state_next = S_MA;
                end
            end
            S_MA:
            begin
                state_next = S_MB;
            end
            S_MB:
            begin
                n_re_next  = sat32(41'(q0) - 41'(q1));
                state_next = S_MC;
            end
            S_MC:
            begin
                w_re_next  = n_re_reg;
                w_im_next  = sat32(41'(q0) + 41'(q1));
                k_next     = k_inc;
                state_next = (k_inc == mults) ? S_ADD : S_MA;
            end
            S_ADD:
            begin
                z_re_next  = sat32(41'(w_re_reg) + 41'(c_re_reg));
                z_im_next  = sat32(41'(w_im_reg) + 41'(c_im_reg));
                count_next = count_inc[15:0];
                state_next = (count_inc >= {1'b0, cfg.max_iterations}) ? S_DINIT : S_SQ;
            end
            S_DINIT:
            begin
                num_next = scaled;
                rem_next = scaled[23:8];
                quo_next = '0;
                bit_next = 3'd7;
                state_next = (cfg.max_iterations == '0) ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                if (trial_ge)
                begin
                    rem_next = 16'(trial - {1'b0, cfg.max_iterations});
                end
                else
                begin
                    rem_next = trial[15:0];
                end
                quo_next = {quo_reg[6:0], trial_ge};
                bit_next = bit_reg - 3'd1;
                if (bit_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    shade_next     = quo_reg;
                    iter_next      = count_reg;
                    escaped_next   = esc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_re_reg    <= c_re_next;
        c_im_reg    <= c_im_next;
        z_re_reg    <= z_re_next;
        z_im_reg    <= z_im_next;
        f_re_reg    <= f_re_next;
        f_im_reg    <= f_im_next;
        w_re_reg    <= w_re_next;
        w_im_reg    <= w_im_next;
        n_re_reg    <= n_re_next;
        p0_reg      <= mul_a0 * mul_b0;
        p1_reg      <= mul_a1 * mul_b1;
        count_reg   <= count_next;
        k_reg       <= k_next;
        esc_reg     <= esc_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        bit_reg     <= bit_next;
        shade_reg   <= shade_next;
        iter_reg    <= iter_next;
        escaped_reg <= escaped_next;
    end

    `BSET_ASSERT_IMPLIES(a_count_within_limit, state_reg != S_IDLE, count_reg <= cfg.max_iterations)
    `BSET_ASSERT_IMPLIES(a_fold_nonnegative, state_reg == S_MA, !f_re_reg[31] && !f_im_reg[31])
    `BSET_ASSERT_IMPLIES(a_escape_before_limit, out_valid_reg && escaped_reg, iter_reg < cfg.max_iterations)
    `BSET_ASSERT_NEXT(a_pop_starts_work, pop_valid && pop_ready, state_reg != S_IDLE)

endmodule

[src/burning_ship_escape_time.sv]
// Burning Ship escape-time pixel evaluator. Each pixel word yields one result word.
// A pixel is held in the front-end register, where c is formed, and then enters
// a two-entry queue; the iteration engine takes it from there. Each full round runs
// the squares (S_SQ), the escape compare (S_CMP), p-1 complex multiplies, where p is
// the clamped exponent (2..6), each through S_MA, S_MB and S_MC on the two shared
// 32x32 multipliers, and the add of c (S_ADD); an escaping round ends after the squares
// and compare. The shade divider then loads its operands (S_DINIT) and forms one
// quotient bit a cycle (S_DIV), and S_DONE loads the result register. A zero iteration
// limit skips the rounds and the quotient steps. The engine can take a new pixel while
// its result word waits to be taken, but S_DONE holds the next result until that word is taken.
// Configuration is held in registers here; cfg is always ready.
// depends on bset_pkg, bset_if, bset_front, bset_queue, bset_back
module burning_ship_escape_time
    import bset_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bset_cfg_if.sink      cfg,
    bset_pixel_if.sink    pixel,
    bset_result_if.source result
);

    cfg_t cfg_reg;
    logic push_valid;
    logic push_ready;
    job_t push_data;
    logic pop_valid;
    logic pop_ready;
    job_t pop_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_re      <= ResetOriginRe;
            cfg_reg.origin_im      <= ResetOriginIm;
            cfg_reg.pixel_step     <= ResetPixelStep;
            cfg_reg.max_iterations <= ResetMaxIter;
            cfg_reg.exponent       <= ResetExponent;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                RegOriginRe:  cfg_reg.origin_re      <= $signed(cfg.data);
                RegOriginIm:  cfg_reg.origin_im      <= $signed(cfg.data);
                RegPixelStep: cfg_reg.pixel_step     <= cfg.data[24:0];
                RegMaxIter:   cfg_reg.max_iterations <= cfg.data[15:0];
                RegExponent:  cfg_reg.exponent       <= cfg.data[2:0];
                default:
                begin
                end
            endcase
        end
    end

    bset_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pixel      (pixel),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bset_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bset_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule

[dv/burning_ship_escape_time_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for burning_ship_escape_time: pixel words in, escape words out
// a directed table then random settings; words checked against the table or a local predictor
// depends on bset_pkg, bset_if and the block itself
module burning_ship_escape_time_test;
    import bset_pkg::*;

    localparam int RandomItems = 1030;
    localparam int HoldCycles  = 3000;
    localparam logic [CfgIndexW-1:0] RegSpare = 3'd5;
    localparam longint QHigh = 64'sd2147483647;
    localparam longint QLow  = -64'sd2147483648;
    localparam longint unsigned EscapeMag = 64'h0004_0000_0000_0000;

    typedef struct packed {
        logic [7:0]  shade;
        logic [15:0] iteration_count;
        logic        escaped;
    } escape_word_t;

    typedef enum logic {RowReg, RowPixel} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CfgIndexW-1:0] index;
        logic [31:0]          data;
        logic [CoordW-1:0]    px;
        logic [CoordW-1:0]    py;
        bit                   known;
        escape_word_t         word;
    } stim_row_t;

    logic clk;
    logic rst_n;

    bset_cfg_if    cfg_ch ();
    bset_pixel_if  pixel_ch ();
    bset_result_if result_ch ();

    burning_ship_escape_time u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .pixel  (pixel_ch),
        .result (result_ch)
    );

    cfg_t         view_regs;
    escape_word_t escape_words_due[$];
    stim_row_t    directed_rows[$];

    int     errors;
    int     words_checked;
    int     escaped_seen;
    int     writes_done;
    longint cycles;
    longint budget;
    bit     calm;
    bit     hold_request;
    int     hold_left;
    int     stall_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // q8.24 helpers for the predictor
    function automatic logic signed [31:0] clamp_q824(input longint v);
        if (v > QHigh)
        begin
            return 32'sh7fff_ffff;
        end
        if (v < QLow)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic longint qmul24(input logic signed [31:0] a, input logic signed [31:0] b);
        return (longint'(a) * longint'(b)) >>> 24;
    endfunction

    function automatic logic signed [31:0] fold_q824(input logic signed [31:0] a);
        if (a == 32'sh8000_0000)
        begin
            return 32'sh7fff_ffff;
        end
        return (a < 0) ? -a : a;
    endfunction

    function automatic escape_word_t predict_escape(input logic [CoordW-1:0] px,
                                                    input logic [CoordW-1:0] py);
        logic signed [31:0] cre;
        logic signed [31:0] cim;
        logic signed [31:0] zre;
        logic signed [31:0] zim;
        logic signed [31:0] fre;
        logic signed [31:0] fim;
        logic signed [31:0] wre;
        logic signed [31:0] wim;
        logic signed [31:0] nre;
        longint unsigned    mag;
        int unsigned        power;
        int unsigned        count;
        bit                 esc;
        escape_word_t       word;
        power = view_regs.exponent;
        if (power < 2)
        begin
            power = 2;
        end
        if (power > 6)
        begin
            power = 6;
        end
        cre = clamp_q824(longint'(view_regs.origin_re)
                         + longint'(px) * longint'(view_regs.pixel_step));
        cim = clamp_q824(longint'(view_regs.origin_im)
                         + longint'(py) * longint'(view_regs.pixel_step));
        zre = '0;
        zim = '0;
        count = 0;
        esc = 1'b0;
        while (count < view_regs.max_iterations)
        begin
            mag = $unsigned(longint'(zre) * longint'(zre))
                  + $unsigned(longint'(zim) * longint'(zim));
            if (mag >= EscapeMag)
            begin
                esc = 1'b1;
                break;
            end
            fre = fold_q824(zre);
            fim = fold_q824(zim);
            wre = fre;
            wim = fim;
            for (int unsigned k = 1; k < power; k++)
            begin
                nre = clamp_q824(qmul24(wre, fre) - qmul24(wim, fim));
                wim = clamp_q824(qmul24(wre, fim) + qmul24(wim, fre));
                wre = nre;
            end
            zre = clamp_q824(longint'(wre) + longint'(cre));
            zim = clamp_q824(longint'(wim) + longint'(cim));
            count++;
        end
        word.shade = (view_regs.max_iterations == 0) ? 8'd0
                   : 8'((255 * count) / view_regs.max_iterations);
        word.iteration_count = count[15:0];
        word.escaped = esc;
        return word;
    endfunction

    function automatic stim_row_t reg_row(input logic [CfgIndexW-1:0] index,
                                          input logic [31:0] data);
        stim_row_t row;
        row = '{kind: RowReg, index: index, data: data, px: '0, py: '0, known: 1'b0, word: '0};
        return row;
    endfunction

    function automatic stim_row_t pixel_row(input logic [CoordW-1:0] px,
                                            input logic [CoordW-1:0] py,
                                            input bit known, input escape_word_t word);
        stim_row_t row;
        row = '{kind: RowPixel, index: '0, data: '0, px: px, py: py, known: known, word: word};
        return row;
    endfunction

    // wait until every expected word has come back, with the pixel channel quiet
    task automatic drain;
        @(negedge clk);
        pixel_ch.valid <= 1'b0;
        while (escape_words_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] index, input logic [31:0] data);
        drain();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        case (index)
            RegOriginRe:  view_regs.origin_re      = data;
            RegOriginIm:  view_regs.origin_im      = data;
            RegPixelStep: view_regs.pixel_step     = data[24:0];
            RegMaxIter:   view_regs.max_iterations = data[15:0];
            RegExponent:  view_regs.exponent       = data[2:0];
            default:      ;
        endcase
        writes_done++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic offer_pixel(input logic [CoordW-1:0] px, input logic [CoordW-1:0] py,
                               input escape_word_t want);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        budget += (longint'(want.iteration_count) + 2) * 21 + 64;
        @(negedge clk);
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_ch.valid   <= 1'b1;
        pixel_ch.pixel_x <= px;
        pixel_ch.pixel_y <= py;
        @(posedge clk);
        while (!pixel_ch.ready)
        begin
            @(posedge clk);
        end
        escape_words_due.push_back(want);
    endtask

    // result side: random stall bursts, one long hold on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HoldCycles;
            result_ch.ready <= 1'b0;
        end
        else if (calm)
        begin
            result_ch.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 4) - 1;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_result
        escape_word_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (escape_words_due.size() == 0)
            begin
                $display("%0t: unexpected word shade %0d count %0d escaped %0d", $time,
                         result_ch.shade, result_ch.iteration_count, result_ch.escaped);
                errors++;
            end
            else
            begin
                want = escape_words_due.pop_front();
                if (result_ch.shade !== want.shade)
                begin
                    $display("%0t: shade expected %0d got %0d", $time, want.shade,
                             result_ch.shade);
                    errors++;
                end
                if (result_ch.iteration_count !== want.iteration_count)
                begin
                    $display("%0t: iteration_count expected %0d got %0d", $time,
                             want.iteration_count, result_ch.iteration_count);
                    errors++;
                end
                if (result_ch.escaped !== want.escaped)
                begin
                    $display("%0t: escaped expected %0d got %0d", $time, want.escaped,
                             result_ch.escaped);
                    errors++;
                end
                escaped_seen += want.escaped;
            end
            words_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 4 * budget + 200000)
        begin
            $display("timeout after %0d cycles, %0d words still due", cycles,
                     escape_words_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        escape_word_t      want;
        logic [CoordW-1:0] px;
        logic [CoordW-1:0] py;
        logic [31:0]       re;
        logic [31:0]       im;
        logic [31:0]       step;
        logic [31:0]       limit;
        logic [31:0]       power;
        int                phase_kind;
        int                phases_run;
        int                batch;
        int                attempts;
        int                random_sent;

        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        pixel_ch.valid = 1'b0;
        pixel_ch.pixel_x = '0;
        pixel_ch.pixel_y = '0;
        result_ch.ready = 1'b0;
        errors = 0;
        words_checked = 0;
        escaped_seen = 0;
        writes_done = 0;
        cycles = 0;
        budget = HoldCycles + 1000;
        calm = 1'b0;
        hold_request = 1'b0;
        hold_left = 0;
        stall_left = 0;
        phases_run = 0;
        random_sent = 0;
        view_regs = '{origin_re: ResetOriginRe, origin_im: ResetOriginIm,
                      pixel_step: ResetPixelStep, max_iterations: ResetMaxIter,
                      exponent: ResetExponent};

        // reset view
        directed_rows.push_back(pixel_row(10'd0, 10'd0, 0, '0));
        directed_rows.push_back(pixel_row(10'd1023, 10'd1023, 0, '0));
        directed_rows.push_back(pixel_row(10'd700, 10'd469, 0, '0));
        directed_rows.push_back(pixel_row(10'h155, 10'h2aa, 0, '0));
        // zero and single iteration limits
        directed_rows.push_back(reg_row(RegMaxIter, 32'd0));
        directed_rows.push_back(pixel_row(10'd10, 10'd10, 1, '{8'd0, 16'd0, 1'b0}));
        directed_rows.push_back(reg_row(RegMaxIter, 32'd1));
        directed_rows.push_back(pixel_row(10'd1023, 10'd0, 1, '{8'd255, 16'd1, 1'b0}));
        // c = 1.5: escapes after the second update
        directed_rows.push_back(reg_row(RegOriginRe, 32'd25165824));
        directed_rows.push_back(reg_row(RegOriginIm, 32'd0));
        directed_rows.push_back(reg_row(RegMaxIter, 32'd2));
        directed_rows.push_back(pixel_row(10'd0, 10'd0, 1, '{8'd255, 16'd2, 1'b0}));
        directed_rows.push_back(reg_row(RegMaxIter, 32'd3));
        directed_rows.push_back(pixel_row(10'd0, 10'd0, 1, '{8'd170, 16'd2, 1'b1}));
        directed_rows.push_back(reg_row(RegMaxIter, 32'd65535));
        directed_rows.push_back(pixel_row(10'd0, 10'd0, 1, '{8'd0, 16'd2, 1'b1}));
        // saturating c, unit and zero steps, exponent codes clamped at both ends
        directed_rows.push_back(reg_row(RegExponent, 32'd6));
        directed_rows.push_back(reg_row(RegPixelStep, 32'h0100_0000));
        directed_rows.push_back(reg_row(RegOriginRe, 32'h7fff_ffff));
        directed_rows.push_back(pixel_row(10'd1023, 10'd0, 1, '{8'd0, 16'd1, 1'b1}));
        directed_rows.push_back(reg_row(RegOriginRe, 32'h8000_0000));
        directed_rows.push_back(reg_row(RegOriginIm, 32'h8000_0000));
        directed_rows.push_back(reg_row(RegExponent, 32'd7));
        directed_rows.push_back(pixel_row(10'd0, 10'd1023, 1, '{8'd0, 16'd1, 1'b1}));
        directed_rows.push_back(pixel_row(10'd1023, 10'd1023, 1, '{8'd0, 16'd1, 1'b1}));
        directed_rows.push_back(reg_row(RegOriginIm, 32'h7fff_ffff));
        directed_rows.push_back(reg_row(RegPixelStep, 32'd0));
        directed_rows.push_back(reg_row(RegExponent, 32'd0));
        directed_rows.push_back(pixel_row(10'd5, 10'd5, 1, '{8'd0, 16'd1, 1'b1}));
        directed_rows.push_back(reg_row(RegExponent, 32'd1));
        directed_rows.push_back(pixel_row(10'd1023, 10'd1023, 1, '{8'd0, 16'd1, 1'b1}));
        // unmapped index changes nothing
        directed_rows.push_back(reg_row(RegSpare, 32'hffff_ffff));
        directed_rows.push_back(pixel_row(10'd1, 10'd2, 0, '0));
        // 4x4 view centered on zero, one unit per 256 pixels
        directed_rows.push_back(reg_row(RegOriginRe, 32'hfe00_0000));
        directed_rows.push_back(reg_row(RegOriginIm, 32'hfe00_0000));
        directed_rows.push_back(reg_row(RegPixelStep, 32'h0001_0000));
        directed_rows.push_back(reg_row(RegMaxIter, 32'd64));
        directed_rows.push_back(reg_row(RegExponent, 32'd2));
        directed_rows.push_back(pixel_row(10'd512, 10'd512, 1, '{8'd255, 16'd64, 1'b0}));
        directed_rows.push_back(pixel_row(10'd300, 10'd450, 0, '0));
        directed_rows.push_back(pixel_row(10'd640, 10'd480, 0, '0));
        directed_rows.push_back(pixel_row(10'd1023, 10'd1023, 0, '0));
        directed_rows.push_back(reg_row(RegExponent, 32'd3));
        directed_rows.push_back(pixel_row(10'd400, 10'd400, 0, '0));
        directed_rows.push_back(pixel_row(10'd700, 10'd300, 0, '0));
        directed_rows.push_back(reg_row(RegExponent, 32'd5));
        directed_rows.push_back(pixel_row(10'h2aa, 10'h155, 0, '0));
        directed_rows.push_back(reg_row(RegExponent, 32'd4));
        directed_rows.push_back(pixel_row(10'd460, 10'd500, 0, '0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == RowReg)
            begin
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end
            else
            begin
                want = predict_escape(directed_rows[i].px, directed_rows[i].py);
                if (directed_rows[i].known)
                begin
                    want = directed_rows[i].word;
                end
                offer_pixel(directed_rows[i].px, directed_rows[i].py, want);
            end
        end

        while (random_sent < RandomItems)
        begin
            phase_kind = (phases_run == 2) ? 0 : $urandom_range(0, 9);
            power = $urandom();
            if (phase_kind <= 5)
            begin
                // around the ship itself
                re = $urandom_range(0, 25165824) - 41943040;
                im = -$urandom_range(0, 41943040) + 8388608;
                step = $urandom_range(256, 65536);
                limit = $urandom_range(1, 48);
            end
            else if (phase_kind <= 7)
            begin
                re = $urandom();
                im = $urandom();
                step = $urandom();
                limit = $urandom();
            end
            else if (phase_kind == 8)
            begin
                // deep limit, cheap exponent
                re = $urandom_range(0, 25165824) - 41943040;
                im = -$urandom_range(0, 33554432);
                step = $urandom_range(1024, 65536);
                limit = $urandom_range(200, 300);
                power = $urandom_range(2, 3);
            end
            else
            begin
                re = ($urandom_range(0, 1) == 0) ? 32'h7fff_ffff : 32'h8000_0000;
                im = ($urandom_range(0, 2) == 0) ? $urandom() : 32'h8000_0000;
                step = ($urandom_range(0, 1) == 0) ? 32'hffff_ffff : 32'h0100_0000;
                limit = ($urandom_range(0, 1) == 0) ? 32'hffff_ffff : 32'd0;
            end
            write_reg(RegOriginRe, re);
            write_reg(RegOriginIm, im);
            write_reg(RegPixelStep, step);
            write_reg(RegMaxIter, limit);
            write_reg(RegExponent, power);
            if ($urandom_range(0, 7) == 0)
            begin
                write_reg(RegSpare, $urandom());
            end
            if (phases_run == 2)
            begin
                hold_request = 1'b1;
                budget += HoldCycles;
            end
            batch = (phase_kind == 8) ? 6 : $urandom_range(8, 40);
            attempts = 0;
            while (batch > 0 && attempts < 200 && random_sent < RandomItems)
            begin
                attempts++;
                px = $urandom_range(0, 1023);
                py = $urandom_range(0, 1023);
                want = predict_escape(px, py);
                // keep slow interior points out of the wide limits
                if (view_regs.max_iterations > 300 && want.iteration_count > 64)
                begin
                    continue;
                end
                calm = (random_sent >= RandomItems - 100);
                offer_pixel(px, py, want);
                batch--;
                random_sent++;
            end
            drain();
            phases_run++;
        end

        drain();
        repeat (50) @(posedge clk);
        $display("checked %0d escape words (%0d escaped) over %0d register writes in %0d phases",
                 words_checked, escaped_seen, writes_done, phases_run);
        $display("covered zero and full iteration limits, all exponent codes, saturated c,");
        $display("and a long hold on the result side");
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[burning_ship_escape_time.f]
+incdir+src
src/bset_pkg.sv
src/bset_if.sv
src/bset_front.sv
src/bset_queue.sv
src/bset_back.sv
src/burning_ship_escape_time.sv
dv/burning_ship_escape_time_test.sv
